>>> hdl/scb_pkg.sv
// Shared types and constants for the segment cell binning block.
// Used by the divider, datapath, controller and top level; no dependencies.
package scb_pkg;

    localparam int GRID_MAX      = 64;
    localparam int MAX_CELLS_DEF = 64;

    localparam int COORD_W    = 32;
    localparam int SCALE_W    = 32;
    localparam int N_W        = 7;
    localparam int IDX_W      = 34;
    localparam int PROD_W     = 66;
    localparam int ID_W       = 12;
    localparam int CELL_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVERTED = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_BOX,
        CMD_MUL_YLO,
        CMD_MUL_YHI,
        CMD_MUL_XLO,
        CMD_MUL_XHI,
        CMD_MUL_SHEAR,
        CMD_SET_YL,
        CMD_SET_YU,
        CMD_SET_XL,
        CMD_SET_XU,
        CMD_SET_JJ_RND,
        CMD_SET_JJ_YL,
        CMD_SET_II_RND,
        CMD_SET_II_XL,
        CMD_DIV_J,
        CMD_DIV_I,
        CMD_TAKE_J,
        CMD_TAKE_I,
        CMD_SHEAR,
        CMD_CLAMP,
        CMD_ROW_INIT,
        CMD_EMIT,
        CMD_MARK_INV,
        CMD_DRAIN
    } cmd_t;

    typedef struct packed {
        logic op_point;
        logic periodic;
        logic inv_box;
        logic inv_y;
        logic inv_x;
        logic inv_np;
        logic div_done;
        logic at_max;
        logic row_end;
        logic last_row;
        logic drain_done;
    } dp_status_t;

endpackage

>>> hdl/scb_div.sv
// Sequential floor divider: signed cell index by an unsigned grid count.
// One quotient bit per cycle; depends on scb_pkg.
module scb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [scb_pkg::IDX_W-1:0] dividend,
    input  logic [scb_pkg::N_W-1:0]     divisor,
    output logic                        done,
    output logic signed [scb_pkg::IDX_W-1:0] quotient,
    output logic [scb_pkg::N_W-1:0]     remainder
);
    import scb_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    acc_reg, acc_next;
    logic [N_W-1:0]      rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [N_W-1:0]      dvs_reg, dvs_next;
    logic [N_W:0]        trial;
    logic                fits;

    always_comb
    begin
        trial = {rem_reg, acc_reg[IDX_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(IDX_W);
            acc_next  = dividend[IDX_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            neg_next  = dividend[IDX_W-1];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? N_W'(trial - {1'b0, dvs_reg}) : trial[N_W-1:0];
            acc_next = {acc_reg[IDX_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
    end

    // Floor semantics: a negative dividend with a nonzero remainder rounds down.
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
        begin
            quotient  = ~acc_reg;
            remainder = dvs_reg - rem_reg;
        end
        else if (neg_reg)
        begin
            quotient  = ~acc_reg + 1'b1;
            remainder = '0;
        end
        else
        begin
            quotient  = acc_reg;
            remainder = rem_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> hdl/scb_dp.sv
// Datapath of the cell binning block: configuration, index scaling multiplier,
// bounds, cell walk, result buffer and output register. Uses scb_pkg and scb_div.
module scb_dp #(
    parameter int MAX_CELLS = scb_pkg::MAX_CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scb_pkg::cmd_t                   cmd,
    output scb_pkg::dp_status_t             status,
    input  logic                            cfg_wen,
    input  logic [scb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_operation,
    input  logic [scb_pkg::COORD_W-1:0]     in_end0_x,
    input  logic [scb_pkg::COORD_W-1:0]     in_end0_y,
    input  logic [scb_pkg::COORD_W-1:0]     in_end1_x,
    input  logic [scb_pkg::COORD_W-1:0]     in_end1_y,
    input  logic [scb_pkg::COORD_W-1:0]     in_disp_x,
    input  logic [scb_pkg::COORD_W-1:0]     in_disp_y,
    input  logic [scb_pkg::ID_W-1:0]        in_chain_index,
    input  logic [scb_pkg::ID_W-1:0]        in_link_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [scb_pkg::CELL_W-1:0]      out_cell_x,
    output logic [scb_pkg::CELL_W-1:0]      out_cell_y,
    output logic [scb_pkg::ID_W-1:0]        out_chain_index,
    output logic [scb_pkg::ID_W-1:0]        out_link_index,
    output logic                            out_last,
    output logic [scb_pkg::STATUS_W-1:0]    out_status
);
    import scb_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int AW    = $clog2(MAX_CELLS);

    // Configuration registers
    logic [N_W-1:0]          grid_x_reg, grid_y_reg;
    logic [SCALE_W-1:0]      scale_x_reg, scale_y_reg;
    logic                    periodic_reg;
    logic [COORD_W-1:0]      shear_reg;

    // Item registers
    logic                    op_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, dx_reg, dy_reg;
    logic [ID_W-1:0]         chain_reg, link_reg;

    // Box and index registers
    logic signed [COORD_W-1:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg, sxlo_reg, sxhi_reg;
    logic signed [COORD_W-1:0] xlo_next, xhi_next, ylo_next, yhi_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [N_W-1:0]            prod_n_reg;
    logic signed [IDX_W-1:0]   xl_reg, xu_reg, yl_reg, yu_reg, ii_reg, jj_reg;
    logic [N_W-1:0]            i_reg, j_reg;
    logic [COORD_W-1:0]        q_reg;

    // Control registers
    logic [CNT_W-1:0]        count_reg, rd_ptr_reg;
    logic                    inverted_reg, trunc_reg, clamped_reg;
    logic                    out_valid_reg;
    logic [2*CELL_W-1:0]     rd_word_reg;
    logic                    out_last_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [ID_W-1:0]         out_chain_reg, out_link_reg;
    logic [2*CELL_W-1:0]     cell_mem_reg [MAX_CELLS];

    logic [N_W-1:0]          nx, ny;
    logic signed [COORD_W-1:0] mul_a;
    logic [SCALE_W-1:0]      mul_b;
    logic [N_W-1:0]          mul_n;
    logic                    mul_half, mul_en;
    logic signed [SCALE_W:0] mul_b_ext;
    logic signed [COORD_W+SCALE_W:0] mul_p;
    logic signed [IDX_W-1:0] floor_v, ceil_v, round_v;
    logic [31:0]             frac;
    logic signed [IDX_W-1:0] nxm1, nym1;
    logic                    at_max, row_end, last_row;
    logic [N_W-1:0]          i_inc, j_inc;
    logic                    div_start, div_done;
    logic signed [IDX_W-1:0] div_dividend, div_quo;
    logic [N_W-1:0]          div_divisor, div_rem;
    logic [CNT_W-1:0]        drain_len;
    logic                    load;
    logic                    mem_we;
    logic [STATUS_W-1:0]     item_status;

    function automatic logic [N_W-1:0] eff_n(input logic [N_W-1:0] g);
        if (g == '0)
            return N_W'(1);
        else if (g > N_W'(GRID_MAX))
            return N_W'(GRID_MAX);
        else
            return g;
    endfunction

    assign nx   = eff_n(grid_x_reg);
    assign ny   = eff_n(grid_y_reg);
    assign nxm1 = IDX_W'(nx) - 1'b1;
    assign nym1 = IDX_W'(ny) - 1'b1;

    // Bounding box of the item
    always_comb
    begin
        if (op_reg)
        begin
            xlo_next = x0_reg;
            xhi_next = x0_reg;
            ylo_next = y0_reg;
            yhi_next = y0_reg;
        end
        else if (periodic_reg)
        begin
            if (!dy_reg[COORD_W-1])
            begin
                ylo_next = y0_reg;
                yhi_next = y0_reg + dy_reg;
                xlo_next = dx_reg[COORD_W-1] ? x0_reg + dx_reg : x0_reg;
                xhi_next = dx_reg[COORD_W-1] ? x0_reg : x0_reg + dx_reg;
            end
            else
            begin
                ylo_next = y1_reg;
                yhi_next = y1_reg - dy_reg;
                xlo_next = dx_reg[COORD_W-1] ? x1_reg : x1_reg - dx_reg;
                xhi_next = dx_reg[COORD_W-1] ? x1_reg - dx_reg : x1_reg;
            end
        end
        else
        begin
            xlo_next = dx_reg[COORD_W-1] ? x1_reg : x0_reg;
            xhi_next = dx_reg[COORD_W-1] ? x0_reg : x1_reg;
            ylo_next = dy_reg[COORD_W-1] ? y1_reg : y0_reg;
            yhi_next = dy_reg[COORD_W-1] ? y0_reg : y1_reg;
        end
    end

    // Shared multiplier: coordinate times scale, or wrap count times shear.
    always_comb
    begin
        mul_a    = ylo_reg;
        mul_b    = scale_y_reg;
        mul_n    = ny;
        mul_half = 1'b1;
        mul_en   = 1'b1;
        case (cmd)
            CMD_MUL_YLO:
            begin
                mul_a = ylo_reg;
            end
            CMD_MUL_YHI:
            begin
                mul_a = yhi_reg;
            end
            CMD_MUL_XLO:
            begin
                mul_a = sxlo_reg;
                mul_b = scale_x_reg;
                mul_n = nx;
            end
            CMD_MUL_XHI:
            begin
                mul_a = sxhi_reg;
                mul_b = scale_x_reg;
                mul_n = nx;
            end
            CMD_MUL_SHEAR:
            begin
                mul_a    = q_reg;
                mul_b    = shear_reg;
                mul_half = 1'b0;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
        mul_b_ext = {1'b0, mul_b};
        mul_p     = mul_a * mul_b_ext;
    end

    // Index from the scaled product: V = p/2^32 + n/2.
    always_comb
    begin
        frac    = prod_reg[31:0];
        floor_v = prod_reg[PROD_W-1:32] + IDX_W'(prod_n_reg >> 1);
        ceil_v  = floor_v + IDX_W'(frac != '0);
        if ((frac == 32'h8000_0000) && floor_v[IDX_W-1])
            round_v = floor_v;
        else
            round_v = floor_v + IDX_W'(frac[31]);
    end

    assign at_max   = count_reg == CNT_W'(MAX_CELLS);
    assign row_end  = ii_reg == xu_reg;
    assign last_row = jj_reg == yu_reg;
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign mem_we   = (cmd == CMD_EMIT) && !at_max;

    assign div_start    = (cmd == CMD_DIV_J) || (cmd == CMD_DIV_I);
    assign div_dividend = (cmd == CMD_DIV_I) ? ii_reg : jj_reg;
    assign div_divisor  = (cmd == CMD_DIV_I) ? nx : ny;

    scb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign drain_len = inverted_reg ? CNT_W'(1) : count_reg;
    assign load      = (cmd == CMD_DRAIN) && (rd_ptr_reg != drain_len) &&
                       (!out_valid_reg || out_ready);

    always_comb
    begin
        if (inverted_reg)
            item_status = ST_INVERTED;
        else if (trunc_reg)
            item_status = ST_TRUNC;
        else if (clamped_reg)
            item_status = ST_CLAMPED;
        else
            item_status = ST_OK;
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg    <= N_W'(8);
            grid_y_reg    <= N_W'(8);
            scale_x_reg   <= SCALE_W'(65536);
            scale_y_reg   <= SCALE_W'(65536);
            periodic_reg  <= 1'b0;
            shear_reg     <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            inverted_reg  <= 1'b0;
            trunc_reg     <= 1'b0;
            clamped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_GRID_X:   grid_x_reg   <= cfg_wdata[N_W-1:0];
                    CFG_GRID_Y:   grid_y_reg   <= cfg_wdata[N_W-1:0];
                    CFG_SCALE_X:  scale_x_reg  <= cfg_wdata[SCALE_W-1:0];
                    CFG_SCALE_Y:  scale_y_reg  <= cfg_wdata[SCALE_W-1:0];
                    CFG_PERIODIC: periodic_reg <= cfg_wdata[0];
                    CFG_SHEAR:    shear_reg    <= cfg_wdata[COORD_W-1:0];
                    default:      ;
                endcase
            end
            case (cmd)
                CMD_CAPTURE:
                begin
                    count_reg    <= '0;
                    rd_ptr_reg   <= '0;
                    inverted_reg <= 1'b0;
                    trunc_reg    <= 1'b0;
                    clamped_reg  <= 1'b0;
                end
                CMD_MARK_INV:
                begin
                    inverted_reg <= 1'b1;
                end
                CMD_CLAMP:
                begin
                    if (xl_reg < 0 || xl_reg > nxm1 || xu_reg < 0 || xu_reg > nxm1 ||
                        yl_reg < 0 || yl_reg > nym1 || yu_reg < 0 || yu_reg > nym1)
                        clamped_reg <= 1'b1;
                end
                CMD_EMIT:
                begin
                    if (at_max)
                        trunc_reg <= 1'b1;
                    else
                        count_reg <= count_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            if (load)
            begin
                rd_ptr_reg    <= rd_ptr_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg   <= {mul_p[COORD_W+SCALE_W], mul_p} +
                          ((mul_half && mul_n[0]) ? (PROD_W'(1) << 31) : PROD_W'(0));
            prod_n_reg <= mul_n;
        end
        case (cmd)
            CMD_CAPTURE:
            begin
                op_reg    <= in_operation;
                x0_reg    <= in_end0_x;
                y0_reg    <= in_end0_y;
                x1_reg    <= in_end1_x;
                y1_reg    <= in_end1_y;
                dx_reg    <= in_disp_x;
                dy_reg    <= in_disp_y;
                chain_reg <= in_chain_index;
                link_reg  <= in_link_index;
            end
            CMD_BOX:
            begin
                xlo_reg  <= xlo_next;
                xhi_reg  <= xhi_next;
                ylo_reg  <= ylo_next;
                yhi_reg  <= yhi_next;
                sxlo_reg <= xlo_next;
                sxhi_reg <= xhi_next;
            end
            CMD_SHEAR:
            begin
                sxlo_reg <= xlo_reg - prod_reg[COORD_W-1:0];
                sxhi_reg <= xhi_reg - prod_reg[COORD_W-1:0];
            end
            CMD_SET_YL:     yl_reg <= floor_v;
            CMD_SET_YU:     yu_reg <= ceil_v;
            CMD_SET_XL:     xl_reg <= floor_v;
            CMD_SET_XU:     xu_reg <= ceil_v;
            CMD_SET_JJ_RND: jj_reg <= round_v;
            CMD_SET_JJ_YL:  jj_reg <= yl_reg;
            CMD_SET_II_RND: ii_reg <= round_v;
            CMD_SET_II_XL:  ii_reg <= xl_reg;
            CMD_TAKE_J:
            begin
                j_reg <= div_rem;
                q_reg <= div_quo[COORD_W-1:0];
            end
            CMD_TAKE_I:     i_reg <= div_rem;
            CMD_CLAMP:
            begin
                if (xl_reg < 0)
                    xl_reg <= '0;
                else if (xl_reg > nxm1)
                    xl_reg <= nxm1;
                if (xu_reg < 0)
                    xu_reg <= '0;
                else if (xu_reg > nxm1)
                    xu_reg <= nxm1;
                if (yl_reg < 0)
                    yl_reg <= '0;
                else if (yl_reg > nym1)
                    yl_reg <= nym1;
                if (yu_reg < 0)
                    yu_reg <= '0;
                else if (yu_reg > nym1)
                    yu_reg <= nym1;
            end
            CMD_ROW_INIT:
            begin
                jj_reg <= yl_reg;
                j_reg  <= yl_reg[N_W-1:0];
                ii_reg <= xl_reg;
                i_reg  <= xl_reg[N_W-1:0];
            end
            CMD_EMIT:
            begin
                if (!at_max)
                begin
                    if (!row_end)
                    begin
                        ii_reg <= ii_reg + 1'b1;
                        i_reg  <= (i_inc == nx) ? '0 : i_inc;
                    end
                    else if (!last_row)
                    begin
                        // Next row; a y wrap adds one more shear offset.
                        jj_reg <= jj_reg + 1'b1;
                        ii_reg <= xl_reg;
                        i_reg  <= xl_reg[N_W-1:0];
                        if (j_inc == ny)
                        begin
                            j_reg <= '0;
                            q_reg <= q_reg + 1'b1;
                        end
                        else
                        begin
                            j_reg <= j_inc;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            out_last_reg   <= (rd_ptr_reg + 1'b1) == drain_len;
            out_status_reg <= item_status;
            out_chain_reg  <= chain_reg;
            out_link_reg   <= link_reg;
        end
    end

    // Result buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem_reg[count_reg[AW-1:0]] <= {j_reg[CELL_W-1:0], i_reg[CELL_W-1:0]};
        if (load)
            rd_word_reg <= cell_mem_reg[rd_ptr_reg[AW-1:0]];
    end

    assign status.op_point   = op_reg;
    assign status.periodic   = periodic_reg;
    assign status.inv_box    = (xlo_reg > xhi_reg) || (ylo_reg > yhi_reg);
    assign status.inv_y      = yl_reg > yu_reg;
    assign status.inv_x      = xl_reg > xu_reg;
    assign status.inv_np     = (xl_reg > xu_reg) || (yl_reg > yu_reg);
    assign status.div_done   = div_done;
    assign status.at_max     = at_max;
    assign status.row_end    = row_end;
    assign status.last_row   = last_row;
    assign status.drain_done = rd_ptr_reg == drain_len;

    assign out_valid       = out_valid_reg;
    assign out_cell_x      = (out_status_reg == ST_INVERTED) ? '0 : rd_word_reg[CELL_W-1:0];
    assign out_cell_y      = (out_status_reg == ST_INVERTED) ? '0 :
                             rd_word_reg[2*CELL_W-1:CELL_W];
    assign out_chain_index = out_chain_reg;
    assign out_link_index  = out_link_reg;
    assign out_last        = out_last_reg;
    assign out_status      = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CELLS))
        else $error("result count above buffer depth");
    a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
        trunc_reg |-> (count_reg == CNT_W'(MAX_CELLS)))
        else $error("truncation flagged with buffer not full");
    a_full_sets_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd == CMD_EMIT) && at_max) |=> trunc_reg)
        else $error("emit at full buffer did not flag truncation");
    a_inverted_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_INVERTED)) |-> out_last_reg)
        else $error("inverted-bounds result is not the last one");
`endif

endmodule

>>> hdl/scb_ctrl.sv
// Controller state machine of the cell binning block.
// Sequences the datapath through commands; depends on scb_pkg.
module scb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scb_pkg::dp_status_t status,
    output scb_pkg::cmd_t       cmd
);
    import scb_pkg::*;

    typedef enum logic [29:0] {
        S_IDLE   = 30'd1 << 0,
        S_BOX    = 30'd1 << 1,
        S_CHKBOX = 30'd1 << 2,
        S_MYLO   = 30'd1 << 3,
        S_SYL    = 30'd1 << 4,
        S_MYHI   = 30'd1 << 5,
        S_SYU    = 30'd1 << 6,
        S_CHKY   = 30'd1 << 7,
        S_PJJ    = 30'd1 << 8,
        S_JJYL   = 30'd1 << 9,
        S_DIVJ   = 30'd1 << 10,
        S_WAITJ  = 30'd1 << 11,
        S_TAKEJ  = 30'd1 << 12,
        S_MSH    = 30'd1 << 13,
        S_SHR    = 30'd1 << 14,
        S_MXLO   = 30'd1 << 15,
        S_PII    = 30'd1 << 16,
        S_SXL    = 30'd1 << 17,
        S_MXHI   = 30'd1 << 18,
        S_SXU    = 30'd1 << 19,
        S_CHK    = 30'd1 << 20,
        S_CLAMP  = 30'd1 << 21,
        S_RINIT  = 30'd1 << 22,
        S_IIXL   = 30'd1 << 23,
        S_DIVI   = 30'd1 << 24,
        S_WAITI  = 30'd1 << 25,
        S_TAKEI  = 30'd1 << 26,
        S_EMIT   = 30'd1 << 27,
        S_INV    = 30'd1 << 28,
        S_DRAIN  = 30'd1 << 29
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                cmd = CMD_BOX;
                if (!status.op_point && status.periodic)
                    state_next = S_CHKBOX;
                else
                    state_next = S_MYLO;
            end
            S_CHKBOX:
            begin
                state_next = status.inv_box ? S_INV : S_MYLO;
            end
            S_MYLO:
            begin
                cmd        = CMD_MUL_YLO;
                state_next = status.op_point ? S_PJJ : S_SYL;
            end
            S_SYL:
            begin
                cmd        = CMD_SET_YL;
                state_next = S_MYHI;
            end
            S_MYHI:
            begin
                cmd        = CMD_MUL_YHI;
                state_next = S_SYU;
            end
            S_SYU:
            begin
                cmd        = CMD_SET_YU;
                state_next = status.periodic ? S_CHKY : S_MXLO;
            end
            S_CHKY:
            begin
                state_next = status.inv_y ? S_INV : S_JJYL;
            end
            S_PJJ:
            begin
                cmd        = CMD_SET_JJ_RND;
                state_next = S_DIVJ;
            end
            S_JJYL:
            begin
                cmd        = CMD_SET_JJ_YL;
                state_next = S_DIVJ;
            end
            S_DIVJ:
            begin
                cmd        = CMD_DIV_J;
                state_next = S_WAITJ;
            end
            S_WAITJ:
            begin
                if (status.div_done)
                    state_next = S_TAKEJ;
            end
            S_TAKEJ:
            begin
                cmd        = CMD_TAKE_J;
                state_next = S_MSH;
            end
            S_MSH:
            begin
                cmd        = CMD_MUL_SHEAR;
                state_next = S_SHR;
            end
            S_SHR:
            begin
                cmd        = CMD_SHEAR;
                state_next = S_MXLO;
            end
            S_MXLO:
            begin
                cmd        = CMD_MUL_XLO;
                state_next = status.op_point ? S_PII : S_SXL;
            end
            S_PII:
            begin
                cmd        = CMD_SET_II_RND;
                state_next = S_DIVI;
            end
            S_SXL:
            begin
                cmd        = CMD_SET_XL;
                state_next = S_MXHI;
            end
            S_MXHI:
            begin
                cmd        = CMD_MUL_XHI;
                state_next = S_SXU;
            end
            S_SXU:
            begin
                cmd        = CMD_SET_XU;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (status.periodic)
                    state_next = status.inv_x ? S_INV : S_IIXL;
                else
                    state_next = status.inv_np ? S_INV : S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd        = CMD_CLAMP;
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd        = CMD_ROW_INIT;
                state_next = S_EMIT;
            end
            S_IIXL:
            begin
                cmd        = CMD_SET_II_XL;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd        = CMD_DIV_I;
                state_next = S_WAITI;
            end
            S_WAITI:
            begin
                if (status.div_done)
                    state_next = S_TAKEI;
            end
            S_TAKEI:
            begin
                cmd        = CMD_TAKE_I;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd = CMD_EMIT;
                if (status.op_point || status.at_max)
                    state_next = S_DRAIN;
                else if (status.row_end)
                begin
                    if (status.last_row)
                        state_next = S_DRAIN;
                    else if (status.periodic)
                        state_next = S_MSH;
                end
            end
            S_INV:
            begin
                cmd        = CMD_MARK_INV;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                cmd = CMD_DRAIN;
                if (status.drain_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/segment_cell_binning_top.sv
// Usage: one input stream of segment or point items, one output stream of cells.
// s_tdata carries the coordinates and identifiers, s_tuser the item kind; each
// item yields one or more cell transactions on the m_* side, the final one with
// m_tlast high and m_tuser giving the item's status.
// Configuration must be written through cfg_wen/cfg_index/cfg_wdata while idle; not enforced.
// One item is handled at a time; s_tready is high only between items.
// A point item runs two divisions that wrap the row and column. A clamped
// segment writes each cell to the result buffer and then streams it. A
// periodic segment runs one row division, then per row a shear multiply,
// scaling and one column division, and also buffers and streams each cell.
// At most MAX_CELLS_PER_ITEM cells are kept in the result buffer, then
// streamed out one per cycle while m_tready is high, from a registered buffer read.
// The next item is taken after the last cell enters the output register and the controller idles.
// If the receiver stalls, the output register holds its transaction and the
// buffer drain waits; nothing is dropped.
// Reset returns the grid to 8 by 8 cells, scale 1.0, clamping mode, zero shear,
// and empties the output register.
// Depends on scb_pkg, scb_ctrl, scb_dp and scb_div.
module segment_cell_binning_top #(
    parameter int MAX_CELLS_PER_ITEM = scb_pkg::MAX_CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [scb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // end0_x, end0_y, end1_x, end1_y, disp_x, disp_y, chain_index, link_index
    input  logic [215:0]                    s_tdata,
    // operation
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_x, cell_y, out_chain_index, out_link_index, zero fill
    output logic [39:0]                     m_tdata,
    output logic                            m_tlast,
    // status
    output logic [1:0]                      m_tuser
);
    import scb_pkg::*;

    cmd_t                 cmd;
    dp_status_t           status;
    logic [CELL_W-1:0]    cell_x, cell_y;
    logic [ID_W-1:0]      chain_o, link_o;

    scb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scb_dp #(
        .MAX_CELLS (MAX_CELLS_PER_ITEM)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_operation    (s_tuser[0]),
        .in_end0_x       (s_tdata[31:0]),
        .in_end0_y       (s_tdata[63:32]),
        .in_end1_x       (s_tdata[95:64]),
        .in_end1_y       (s_tdata[127:96]),
        .in_disp_x       (s_tdata[159:128]),
        .in_disp_y       (s_tdata[191:160]),
        .in_chain_index  (s_tdata[203:192]),
        .in_link_index   (s_tdata[215:204]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_cell_x      (cell_x),
        .out_cell_y      (cell_y),
        .out_chain_index (chain_o),
        .out_link_index  (link_o),
        .out_last        (m_tlast),
        .out_status      (m_tuser)
    );

    assign m_tdata = {4'b0000, link_o, chain_o, cell_y, cell_x};

endmodule

>>> test/tb.sv
// Self-checking testbench for segment_cell_binning_top: directed table, then random phases.
// Every cell transaction is compared with the directed table or a local Q16.16 cell binning predictor.
// Depends on scb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
    import scb_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        bit        op;
        bit [31:0] x0, y0, x1, y1, dx, dy;
        bit [11:0] ch, lk;
    } seg_item_t;

    typedef struct packed {
        bit [5:0]  cx, cy;
        bit [11:0] ch, lk;
        bit        last;
        bit [1:0]  st;
    } cell_t;

    typedef enum bit { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        bit [CFG_IDX_W-1:0]    idx;
        bit [31:0]             val;
        seg_item_t             item;
        bit                    typed;
        cell_t                 want;
    } stim_row_t;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_wen = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [215:0]          s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [39:0]           m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    segment_cell_binning_top uut (.*);

    always #10 clk = ~clk;

    // Shadow copy of the configuration registers.
    bit [6:0]  grid_x_reg, grid_y_reg;
    bit [31:0] scale_x_reg, scale_y_reg, shear_reg;
    bit        periodic_reg;

    cell_t     cells_due[$];
    int        errors = 0;
    int        items_sent = 0;
    int        cells_seen = 0;
    int        settings_used = 1;
    int        burst_left = 0;
    longint    cycle_cnt = 0;
    int        rmode = 0;

    function automatic longint sx32(bit [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint eff_grid(bit [6:0] g);
        if (g == 0) return 1;
        if (g > GRID_MAX) return GRID_MAX;
        return g;
    endfunction

    function automatic longint cell_floor(longint v, longint c, longint n, output bit [31:0] fr);
        longint p;
        p = v * c + (n & 1) * 64'sh80000000;
        fr = p[31:0];
        return (p >>> 32) + (n >> 1);
    endfunction

    function automatic longint cell_ceil(longint v, longint c, longint n);
        bit [31:0] fr;
        longint f;
        f = cell_floor(v, c, n, fr);
        return f + (fr != 0);
    endfunction

    function automatic longint cell_round(longint v, longint c, longint n);
        bit [31:0] fr;
        longint f;
        f = cell_floor(v, c, n, fr);
        if (fr == 32'h8000_0000 && f < 0) return f;
        return f + (fr >= 32'h8000_0000);
    endfunction

    function automatic longint wrap_cell(longint i, longint n, output longint q);
        longint r;
        q = i / n;
        r = i - q * n;
        if (r < 0) begin
            r += n;
            q -= 1;
        end
        return r;
    endfunction

    function automatic longint sheared(longint x, longint q);
        bit [31:0] d;
        bit [31:0] xb;
        d = q[31:0] * shear_reg;
        xb = x[31:0];
        return sx32(xb - d);
    endfunction

    function automatic longint add_q16(longint a, longint b);
        longint s;
        s = a + b;
        return sx32(s[31:0]);
    endfunction

    // Works out the cells of one item and queues them.
    task automatic bin_item(seg_item_t it);
        cell_t  buf_q[$];
        cell_t  c;
        longint nx, ny, sclx, scly;
        longint x0, y0, x1, y1, dx, dy, t;
        longint xl, xu, yl, yu, xlo, xhi, ylo, yhi, i, j, jj, q, dq;
        bit [31:0] fr;
        bit     inv, trunc, clamp;
        bit [1:0] st;
        nx = eff_grid(grid_x_reg);
        ny = eff_grid(grid_y_reg);
        sclx = scale_x_reg;
        scly = scale_y_reg;
        x0 = sx32(it.x0); y0 = sx32(it.y0);
        x1 = sx32(it.x1); y1 = sx32(it.y1);
        dx = sx32(it.dx); dy = sx32(it.dy);
        inv = 0; trunc = 0; clamp = 0;
        c.ch = it.ch; c.lk = it.lk; c.last = 0; c.st = ST_OK;
        if (it.op) begin
            j = wrap_cell(cell_round(y0, scly, ny), ny, q);
            i = wrap_cell(cell_round(sheared(x0, q), sclx, nx), nx, dq);
            c.cx = i[5:0]; c.cy = j[5:0];
            buf_q = {buf_q, c};
        end else if (!periodic_reg) begin
            if (dx < 0) begin t = x0; x0 = x1; x1 = t; end
            if (dy < 0) begin t = y0; y0 = y1; y1 = t; end
            xl = cell_floor(x0, sclx, nx, fr);
            xu = cell_ceil(x1, sclx, nx);
            yl = cell_floor(y0, scly, ny, fr);
            yu = cell_ceil(y1, scly, ny);
            if (xl > xu || yl > yu) inv = 1;
            else begin
                if (xl < 0) begin xl = 0; clamp = 1; end
                if (xl > nx - 1) begin xl = nx - 1; clamp = 1; end
                if (xu < 0) begin xu = 0; clamp = 1; end
                if (xu > nx - 1) begin xu = nx - 1; clamp = 1; end
                if (yl < 0) begin yl = 0; clamp = 1; end
                if (yl > ny - 1) begin yl = ny - 1; clamp = 1; end
                if (yu < 0) begin yu = 0; clamp = 1; end
                if (yu > ny - 1) begin yu = ny - 1; clamp = 1; end
                for (j = yl; j <= yu && !trunc; j++)
                    for (i = xl; i <= xu; i++) begin
                        if (buf_q.size() >= MAX_CELLS_DEF) begin
                            trunc = 1;
                            break;
                        end
                        c.cx = i[5:0]; c.cy = j[5:0];
                        buf_q = {buf_q, c};
                    end
            end
        end else begin
            if (dy >= 0) begin
                ylo = y0; yhi = add_q16(y0, dy);
                if (dx >= 0) begin xlo = x0; xhi = add_q16(x0, dx); end
                else begin xlo = add_q16(x0, dx); xhi = x0; end
            end else begin
                ylo = y1; yhi = add_q16(y1, -dy);
                if (dx >= 0) begin xlo = add_q16(x1, -dx); xhi = x1; end
                else begin xlo = x1; xhi = add_q16(x1, -dx); end
            end
            if (xlo > xhi || ylo > yhi) inv = 1;
            else begin
                yl = cell_floor(ylo, scly, ny, fr);
                yu = cell_ceil(yhi, scly, ny);
                if (yl > yu) inv = 1;
                for (jj = yl; jj <= yu && !trunc && !inv; jj++) begin
                    j = wrap_cell(jj, ny, q);
                    xl = cell_floor(sheared(xlo, q), sclx, nx, fr);
                    xu = cell_ceil(sheared(xhi, q), sclx, nx);
                    if (xl > xu) begin
                        inv = 1;
                        break;
                    end
                    for (i = xl; i <= xu; i++) begin
                        if (buf_q.size() >= MAX_CELLS_DEF) begin
                            trunc = 1;
                            break;
                        end
                        t = wrap_cell(i, nx, dq);
                        c.cx = t[5:0]; c.cy = j[5:0];
                        buf_q = {buf_q, c};
                    end
                end
            end
        end
        if (inv) begin
            buf_q.delete();
            st = ST_INVERTED;
        end else if (trunc) st = ST_TRUNC;
        else if (clamp) st = ST_CLAMPED;
        else st = ST_OK;
        if (buf_q.size() == 0) begin
            c.cx = 0; c.cy = 0;
            buf_q = {buf_q, c};
        end
        foreach (buf_q[k]) begin
            buf_q[k].st = st;
            buf_q[k].last = (k == buf_q.size() - 1);
            cells_due = {cells_due, buf_q[k]};
        end
    endtask

    task automatic wait_idle();
        while (cells_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] val);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 0;
        @(posedge clk);
        case (idx)
            CFG_GRID_X:   grid_x_reg = val[6:0];
            CFG_GRID_Y:   grid_y_reg = val[6:0];
            CFG_SCALE_X:  scale_x_reg = val;
            CFG_SCALE_Y:  scale_y_reg = val;
            CFG_PERIODIC: periodic_reg = val[0];
            CFG_SHEAR:    shear_reg = val;
            default: ;
        endcase
    endtask

    // Sends one item in bursts with random gaps; returns after the transaction.
    task automatic send_item(seg_item_t it, bit typed, cell_t want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tdata <= {it.lk, it.ch, it.dy, it.dx, it.y1, it.x1, it.y0, it.x0};
        s_tuser <= it.op;
        s_tvalid <= 1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        burst_left--;
        if (typed) cells_due = {cells_due, want};
        else bin_item(it);
    endtask

    function automatic bit [31:0] rand_span(bit [31:0] range);
        return $urandom_range(0, range) - (range >> 1);
    endfunction

    function automatic seg_item_t rand_item();
        seg_item_t it;
        it.op = ($urandom_range(0, 3) == 0);
        it.ch = 12'($urandom);
        it.lk = 12'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            it.x0 = $urandom; it.y0 = $urandom; it.x1 = $urandom;
            it.y1 = $urandom; it.dx = $urandom; it.dy = $urandom;
        end else begin
            it.x0 = rand_span(32'h0010_0000);
            it.y0 = rand_span(32'h0010_0000);
            it.dx = rand_span(32'h0004_0000);
            it.dy = rand_span(32'h0004_0000);
            it.x1 = it.x0 + it.dx;
            it.y1 = it.y0 + it.dy;
            // A few boxes whose endpoints disagree with the displacement.
            if ($urandom_range(0, 9) == 0) it.x1 = rand_span(32'h0010_0000);
            if ($urandom_range(0, 9) == 0) it.y1 = rand_span(32'h0010_0000);
        end
        return it;
    endfunction

    function automatic bit [31:0] rand_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 32'hFFFF_FFFF;
        if (r == 2) return $urandom;
        return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endfunction

    function automatic bit [6:0] rand_grid();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'd127;
        if (r == 2) return 7'd64;
        return 7'($urandom_range(1, 16));
    endfunction

    function automatic stim_row_t cfg_row(bit [CFG_IDX_W-1:0] idx, bit [31:0] val);
        stim_row_t r;
        r = '{kind: ROW_CFG, default: '0};
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic stim_row_t item_row(bit op, bit [31:0] x0, y0, x1, y1, dx, dy,
                                           bit typed, bit [5:0] cx, cy, bit [1:0] st);
        stim_row_t r;
        r = '{kind: ROW_ITEM, default: '0};
        r.item.op = op;
        r.item.x0 = x0; r.item.y0 = y0; r.item.x1 = x1;
        r.item.y1 = y1; r.item.dx = dx; r.item.dy = dy;
        r.item.ch = op ? 12'hFFF : 12'h000;
        r.item.lk = op ? 12'h000 : 12'hFFF;
        r.typed = typed;
        r.want.cx = cx; r.want.cy = cy;
        r.want.ch = r.item.ch; r.want.lk = r.item.lk;
        r.want.last = 1; r.want.st = st;
        return r;
    endfunction

    // Result checker.
    always @(posedge clk) begin
        cell_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.cx = m_tdata[5:0];
            got.cy = m_tdata[11:6];
            got.ch = m_tdata[23:12];
            got.lk = m_tdata[35:24];
            got.last = m_tlast;
            got.st = m_tuser;
            cells_seen++;
            if (cells_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected cell transaction, expected none, got %p", $time, got);
            end else begin
                want = cells_due.pop_front();
                if (got != want || m_tdata[39:36] != 0) begin
                    errors++;
                    $display("%0t: cell mismatch, expected %p, got %p", $time, want, got);
                end
            end
        end
    end

    // Receiver stall pattern; the mode is redrawn at random whenever the low byte of cycle_cnt wraps.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt[7:0] == 0) rmode = $urandom_range(0, 3);
        case (rmode)
            0:       m_tready <= 1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= (cycle_cnt % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out with %0d cells outstanding", cells_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        stim_row_t rows[$];
        grid_x_reg = 8; grid_y_reg = 8;
        scale_x_reg = 32'h0001_0000; scale_y_reg = 32'h0001_0000;
        periodic_reg = 0; shear_reg = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Reset settings: centered points and extreme coordinates land in cell (4,4).
        rows = {rows, item_row(1, 0, 0, 0, 0, 0, 0, 1, 4, 4, ST_OK)};
        rows = {rows, item_row(1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 4, 4, ST_OK)};
        rows = {rows, item_row(1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 4, 4, ST_OK)};
        rows = {rows, item_row(0, 0, 0, 0, 0, 0, 0, 1, 4, 4, ST_OK)};
        // Low bound above high bound.
        rows = {rows, item_row(0, 32'h0003_0000, 0, 32'hFFFD_0000, 0, 0, 0,
                               1, 0, 0, ST_INVERTED)};
        rows = {rows, item_row(0, 32'hFF9C_0000, 32'hFF9C_0000, 32'h0064_0000,
                               32'h0064_0000, 32'h00C8_0000, 32'h00C8_0000, 0, 0, 0, 0)};
        rows = {rows, item_row(0, 32'h0001_0000, 32'h0001_8000, 32'hFFFF_0000,
                               32'hFFFF_8000, 32'hFFFE_0000, 32'hFFFE_0000, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_GRID_X, 64)};
        rows = {rows, cfg_row(CFG_GRID_Y, 64)};
        rows = {rows, item_row(0, 32'hFC18_0000, 32'hFC18_0000, 32'h03E8_0000,
                               32'h03E8_0000, 32'h07D0_0000, 32'h07D0_0000, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_GRID_X, 0)};
        rows = {rows, cfg_row(CFG_GRID_Y, 127)};
        rows = {rows, item_row(0, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0010_0000,
                               32'h0010_0000, 32'h0020_0000, 32'h0020_0000, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_SCALE_X, 0)};
        rows = {rows, item_row(1, 32'h1234_5678, 32'h0002_8000, 0, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_GRID_X, 8)};
        rows = {rows, cfg_row(CFG_GRID_Y, 8)};
        rows = {rows, cfg_row(CFG_SCALE_X, 32'h0001_0000)};
        rows = {rows, cfg_row(CFG_PERIODIC, 1)};
        rows = {rows, cfg_row(CFG_SHEAR, 32'h0002_8000)};
        // Boxes that cross a y wrap, so the shear applies.
        rows = {rows, item_row(0, 32'h0001_0000, 32'h0003_8000, 32'h0002_0000,
                               32'h0005_8000, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0)};
        rows = {rows, item_row(1, 32'h0001_0000, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, item_row(0, 0, 32'h7FFF_0000, 0, 0, 0, 32'h0010_0000, 0, 0, 0, 0)};
        rows = {rows, item_row(0, 0, 0, 32'hFFFD_0000, 32'hFFFB_0000,
                               32'hFFFE_0000, 32'hFFF8_0000, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_SHEAR, 32'h8000_0000)};
        rows = {rows, item_row(0, 32'h0002_0000, 32'hFFFA_0000, 32'h0003_0000,
                               32'h000A_0000, 32'h0001_0000, 32'h0010_0000, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_SHEAR, 32'h7FFF_FFFF)};
        rows = {rows, item_row(1, 32'h0002_0000, 32'hFFF0_0000, 0, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, cfg_row(CFG_SCALE_Y, 32'hFFFF_FFFF)};
        rows = {rows, item_row(0, 0, 0, 32'h0000_8000, 32'h0000_0100,
                               32'h0000_8000, 32'h0000_0100, 0, 0, 0, 0)};

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                s_tvalid <= 0;
                burst_left = 0;
                wait_idle();
                write_reg(rows[r].idx, rows[r].val);
                settings_used++;
            end else begin
                send_item(rows[r].item, rows[r].typed, rows[r].want);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            s_tvalid <= 0;
            burst_left = 0;
            wait_idle();
            write_reg(CFG_GRID_X, rand_grid());
            write_reg(CFG_GRID_Y, rand_grid());
            write_reg(CFG_SCALE_X, rand_scale());
            write_reg(CFG_SCALE_Y, rand_scale());
            write_reg(CFG_PERIODIC, ph[0]);
            write_reg(CFG_SHEAR, $urandom);
            settings_used++;
            for (int n = 0; n < 21; n++) send_item(rand_item(), 0, '{default: '0});
        end
        s_tvalid <= 0;

        while (cells_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d items under %0d register settings, checked %0d cells",
                 items_sent, settings_used, cells_seen);
        if (errors == 0 && cells_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> segment_cell_binning_top.f
hdl/scb_pkg.sv
hdl/scb_div.sv
hdl/scb_dp.sv
hdl/scb_ctrl.sv
hdl/segment_cell_binning_top.sv
test/tb.sv
